@@ rtl/vch_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vch_pkg;

  localparam int DEF_MAX_BINS     = 512;
  localparam int DEF_COUNTER_BITS = 32;
  localparam int KINDS            = 5;

  localparam int OP_W     = 1;
  localparam int ROLE_W   = 2;
  localparam int CNT_W    = 16;
  localparam int SEL_W    = 4;
  localparam int IDX_W    = 9;
  localparam int BINCNT_W = 32;
  localparam int EXT_W    = 10;
  localparam int LEN_W    = 10;

  localparam logic [LEN_W-1:0] REF_LEN_RST = 10'd512;

  localparam logic [OP_W-1:0] OP_RECORD = 1'b0;
  localparam logic [OP_W-1:0] OP_READ   = 1'b1;

  localparam logic [ROLE_W-1:0] ROLE_SOLO   = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_FIRST  = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_SECOND = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
    logic clear_wr;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/vch_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface vch_in_if;
  logic                          valid;
  logic                          ready;
  logic [vch_pkg::OP_W-1:0]      op;
  logic [vch_pkg::ROLE_W-1:0]    pair_role;
  logic [vch_pkg::CNT_W-1:0]     mismatch_count;
  logic [vch_pkg::CNT_W-1:0]     insertion_count;
  logic [vch_pkg::CNT_W-1:0]     deletion_count;
  logic [vch_pkg::CNT_W-1:0]     variant_count;
  logic [vch_pkg::CNT_W-1:0]     diff_length;
  logic [vch_pkg::SEL_W-1:0]     table_select;
  logic [vch_pkg::IDX_W-1:0]     bin_index;

  modport source (
    output valid, op, pair_role, mismatch_count, insertion_count, deletion_count,
           variant_count, diff_length, table_select, bin_index,
    input  ready
  );
  modport sink (
    input  valid, op, pair_role, mismatch_count, insertion_count, deletion_count,
           variant_count, diff_length, table_select, bin_index,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/vch_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface vch_out_if;
  logic                            valid;
  logic                            ready;
  logic [vch_pkg::BINCNT_W-1:0]    bin_count;
  logic [vch_pkg::EXT_W-1:0]       extent_single;
  logic [vch_pkg::EXT_W-1:0]       extent_pair;
  logic                            orphan_mate;

  modport source (
    output valid, bin_count, extent_single, extent_pair, orphan_mate,
    input  ready
  );
  modport sink (
    input  valid, bin_count, extent_single, extent_pair, orphan_mate,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/variant_count_histograms.sv @@
// Variant count histograms: ten saturating histograms (five per-read, five per-pair).
// in_ch carries one op per transfer: a record op bumps one bin in every per-read
// histogram (and, for a completed pair, every per-pair histogram); a read op fetches
// one bin of the histogram named by table_select. Every op yields exactly one transfer
// on out_ch with bin_count, the two extents and the orphan flag.
// cfg_* writes ref_length; it is always ready, and the user must write it only while
// the block idles; the block itself does not enforce this. out_ch.valid rises once the
// op has passed the LOOKUP (RAM lookup) and UPDATE (update) states. No next op is taken
// before the cycle after commit, as set by the read-modify-write through the
// registered-read histogram RAMs. Reset (rst_n low, synchronous) clears the extents and
// the held mate, then a clearing pass writes zero to every bin, one address per cycle
// in all ten RAMs at once, during which in_ch.ready stays low.
// When the receiver stalls, a finished result waits in the output register; the next
// op is still accepted and processed up to its update step, where it holds until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none

module variant_count_histograms #(
  parameter int MAX_BINS     = vch_pkg::DEF_MAX_BINS,
  parameter int COUNTER_BITS = vch_pkg::DEF_COUNTER_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  vch_in_if.sink                           in_ch,
  vch_out_if.source                        out_ch,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [vch_pkg::LEN_W-1:0]   cfg_data
);

  vch_pkg::cmd_t cmd;
  vch_pkg::sts_t sts;
  logic          cfg_we;

  // configuration register takes a transfer at any time
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  vch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vch_dp #(
    .MAX_BINS     (MAX_BINS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_op              (in_ch.op),
    .in_pair_role       (in_ch.pair_role),
    .in_mismatch_count  (in_ch.mismatch_count),
    .in_insertion_count (in_ch.insertion_count),
    .in_deletion_count  (in_ch.deletion_count),
    .in_variant_count   (in_ch.variant_count),
    .in_diff_length     (in_ch.diff_length),
    .in_table_select    (in_ch.table_select),
    .in_bin_index       (in_ch.bin_index),
    .out_bin_count      (out_ch.bin_count),
    .out_extent_single  (out_ch.extent_single),
    .out_extent_pair    (out_ch.extent_pair),
    .out_orphan_mate    (out_ch.orphan_mate)
  );

endmodule

`default_nettype wire

@@ rtl/vch_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vch_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 512,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/vch_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vch_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire vch_pkg::sts_t sts,
  output vch_pkg::cmd_t      cmd
);

  vch_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vch_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      vch_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = vch_pkg::ST_IDLE;
        end
      end
      vch_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = vch_pkg::ST_LOOKUP;
        end
      end
      vch_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = vch_pkg::ST_UPDATE;
      end
      vch_pkg::ST_UPDATE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = vch_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vch_pkg::ST_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/vch_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vch_dp #(
  parameter int MAX_BINS     = vch_pkg::DEF_MAX_BINS,
  parameter int COUNTER_BITS = vch_pkg::DEF_COUNTER_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire vch_pkg::cmd_t                   cmd,
  output vch_pkg::sts_t                        sts,
  input  wire logic                            cfg_we,
  input  wire logic [vch_pkg::LEN_W-1:0]       cfg_data,
  input  wire logic [vch_pkg::OP_W-1:0]        in_op,
  input  wire logic [vch_pkg::ROLE_W-1:0]      in_pair_role,
  input  wire logic [vch_pkg::CNT_W-1:0]       in_mismatch_count,
  input  wire logic [vch_pkg::CNT_W-1:0]       in_insertion_count,
  input  wire logic [vch_pkg::CNT_W-1:0]       in_deletion_count,
  input  wire logic [vch_pkg::CNT_W-1:0]       in_variant_count,
  input  wire logic [vch_pkg::CNT_W-1:0]       in_diff_length,
  input  wire logic [vch_pkg::SEL_W-1:0]       in_table_select,
  input  wire logic [vch_pkg::IDX_W-1:0]       in_bin_index,
  output logic      [vch_pkg::BINCNT_W-1:0]    out_bin_count,
  output logic      [vch_pkg::EXT_W-1:0]       out_extent_single,
  output logic      [vch_pkg::EXT_W-1:0]       out_extent_pair,
  output logic                                 out_orphan_mate
);

  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int CB    = COUNTER_BITS;
  localparam int KN    = vch_pkg::KINDS;
  localparam int CMP_W = 18;
  localparam int CW    = vch_pkg::CNT_W;

  localparam logic [CMP_W-1:0] MAX_C    = CMP_W'(MAX_BINS);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(MAX_BINS - 1);

  // item registers
  logic [vch_pkg::OP_W-1:0]   op_r;
  logic [vch_pkg::ROLE_W-1:0] role_r;
  logic [CW-1:0]              cnt_r [KN];
  logic [vch_pkg::SEL_W-1:0]  sel_r;
  logic [vch_pkg::IDX_W-1:0]  idx_r;
  logic [BIN_W-1:0]           bin_s_r [KN];
  logic [BIN_W-1:0]           bin_p_r [KN];

  // architectural state
  logic [CW-1:0]              held_r [KN];
  logic                       held_valid_r;
  logic [BIN_W-1:0]           top_s_r, top_s_nxt;
  logic [BIN_W-1:0]           top_p_r, top_p_nxt;
  logic [vch_pkg::LEN_W-1:0]  ref_len_r;
  logic [BIN_W-1:0]           clr_cnt_r;

  // result registers
  logic [vch_pkg::BINCNT_W-1:0] bin_count_r;
  logic [vch_pkg::EXT_W-1:0]    ext_s_r, ext_p_r;
  logic                         orphan_r;

  logic [CW-1:0]      in_cnt [KN];
  logic [CMP_W-1:0]   ref_ext, eff_len, lim, idx_ext;
  logic [BIN_W-1:0]   bin_s [KN];
  logic [BIN_W-1:0]   bin_p [KN];
  logic [BIN_W-1:0]   raddr_s [KN];
  logic [BIN_W-1:0]   raddr_p [KN];
  logic [BIN_W-1:0]   waddr_s [KN];
  logic [BIN_W-1:0]   waddr_p [KN];
  logic [CB-1:0]      rd_s [KN];
  logic [CB-1:0]      rd_p [KN];
  logic [CB-1:0]      wd_s [KN];
  logic [CB-1:0]      wd_p [KN];
  logic               we_s, we_p;
  logic               is_record, pair_bump, orphan;
  logic               idx_ok;
  logic [CB-1:0]      sel_cnt;
  logic [63:0]        sel_cnt_wide;
  logic [31:0]        ext_s_sum, ext_p_sum;

  assign in_cnt[0] = in_mismatch_count;
  assign in_cnt[1] = in_insertion_count;
  assign in_cnt[2] = in_deletion_count;
  assign in_cnt[3] = in_variant_count;
  assign in_cnt[4] = in_diff_length;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      role_r <= in_pair_role;
      sel_r  <= in_table_select;
      idx_r  <= in_bin_index;
      for (int k = 0; k < KN; k++) begin
        cnt_r[k] <= in_cnt[k];
      end
    end
    if (cmd.lookup) begin
      for (int k = 0; k < KN; k++) begin
        bin_s_r[k] <= bin_s[k];
        bin_p_r[k] <= bin_p[k];
      end
    end
    if (cmd.commit) begin
      bin_count_r <= sel_cnt_wide[vch_pkg::BINCNT_W-1:0];
      ext_s_r     <= ext_s_sum[vch_pkg::EXT_W-1:0];
      ext_p_r     <= ext_p_sum[vch_pkg::EXT_W-1:0];
      orphan_r    <= orphan;
      if (is_record && role_r == vch_pkg::ROLE_FIRST) begin
        for (int k = 0; k < KN; k++) begin
          held_r[k] <= cnt_r[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      top_s_r      <= '0;
      top_p_r      <= '0;
      ref_len_r    <= vch_pkg::REF_LEN_RST;
      clr_cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        ref_len_r <= cfg_data;
      end
      if (cmd.clear_wr) begin
        clr_cnt_r <= clr_cnt_r + BIN_W'(1);
      end
      if (cmd.commit) begin
        top_s_r <= top_s_nxt;
        top_p_r <= top_p_nxt;
        if (is_record && role_r == vch_pkg::ROLE_FIRST) begin
          held_valid_r <= 1'b1;
        end else if (pair_bump) begin
          held_valid_r <= 1'b0;
        end
      end
    end
  end

  assign sts.clear_last = (clr_cnt_r == LAST_BIN);

  // bin selection: clamp to the top bin in use
  always_comb begin
    ref_ext = CMP_W'(ref_len_r);
    if (ref_ext == '0) begin
      eff_len = CMP_W'(1);
    end else if (ref_ext > MAX_C) begin
      eff_len = MAX_C;
    end else begin
      eff_len = ref_ext;
    end
    lim     = eff_len - CMP_W'(1);
    idx_ext = CMP_W'(idx_r);
    idx_ok  = idx_ext < MAX_C;
    for (int k = 0; k < KN; k++) begin
      logic [CMP_W-1:0] vs, vp, cs, cp;
      vs = CMP_W'(cnt_r[k]);
      vp = CMP_W'(held_r[k]) + CMP_W'(cnt_r[k]);
      cs = (vs > lim) ? lim : vs;
      cp = (vp > lim) ? lim : vp;
      bin_s[k]   = cs[BIN_W-1:0];
      bin_p[k]   = cp[BIN_W-1:0];
      raddr_s[k] = (op_r == vch_pkg::OP_READ) ? idx_ext[BIN_W-1:0] : bin_s[k];
      raddr_p[k] = (op_r == vch_pkg::OP_READ) ? idx_ext[BIN_W-1:0] : bin_p[k];
    end
  end

  // read-modify-write and result
  always_comb begin
    is_record = (op_r == vch_pkg::OP_RECORD);
    pair_bump = is_record && role_r == vch_pkg::ROLE_SECOND && held_valid_r;
    orphan    = is_record && role_r == vch_pkg::ROLE_SECOND && !held_valid_r;
    we_s      = cmd.clear_wr || (cmd.commit && is_record);
    we_p      = cmd.clear_wr || (cmd.commit && pair_bump);
    top_s_nxt = top_s_r;
    top_p_nxt = top_p_r;
    sel_cnt   = '0;
    for (int k = 0; k < KN; k++) begin
      waddr_s[k] = cmd.clear_wr ? clr_cnt_r : bin_s_r[k];
      waddr_p[k] = cmd.clear_wr ? clr_cnt_r : bin_p_r[k];
      if (cmd.clear_wr) begin
        wd_s[k] = '0;
        wd_p[k] = '0;
      end else begin
        wd_s[k] = (rd_s[k] == '1) ? rd_s[k] : rd_s[k] + CB'(1);
        wd_p[k] = (rd_p[k] == '1) ? rd_p[k] : rd_p[k] + CB'(1);
      end
      if (is_record && bin_s_r[k] > top_s_nxt) begin
        top_s_nxt = bin_s_r[k];
      end
      if (pair_bump && bin_p_r[k] > top_p_nxt) begin
        top_p_nxt = bin_p_r[k];
      end
      if (sel_r == vch_pkg::SEL_W'(k)) begin
        sel_cnt = rd_s[k];
      end
      if (sel_r == vch_pkg::SEL_W'(k + KN)) begin
        sel_cnt = rd_p[k];
      end
    end
    if (is_record || !idx_ok) begin
      sel_cnt = '0;
    end
    sel_cnt_wide = 64'(sel_cnt);
    ext_s_sum    = 32'(top_s_nxt) + 32'd1;
    ext_p_sum    = 32'(top_p_nxt) + 32'd1;
  end

  for (genvar g = 0; g < KN; g++) begin : g_hist
    vch_ram #(
      .W     (CB),
      .DEPTH (MAX_BINS)
    ) u_single (
      .clk   (clk),
      .we    (we_s),
      .waddr (waddr_s[g]),
      .wdata (wd_s[g]),
      .re    (cmd.lookup),
      .raddr (raddr_s[g]),
      .rdata (rd_s[g])
    );
    vch_ram #(
      .W     (CB),
      .DEPTH (MAX_BINS)
    ) u_pair (
      .clk   (clk),
      .we    (we_p),
      .waddr (waddr_p[g]),
      .wdata (wd_p[g]),
      .re    (cmd.lookup),
      .raddr (raddr_p[g]),
      .rdata (rd_p[g])
    );
  end

  assign out_bin_count     = bin_count_r;
  assign out_extent_single = ext_s_r;
  assign out_extent_pair   = ext_p_r;
  assign out_orphan_mate   = orphan_r;

endmodule

`default_nettype wire

@@ sim/vch_histogram_checker.sv @@
`timescale 1ns / 1ps

module vch_histogram_checker
  import vch_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  vch_in_if                       in_ch,
  vch_out_if                      out_ch,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [LEN_W-1:0]   cfg_data,
  output int unsigned             pending_results,
  output int unsigned             mismatches
);

  localparam int unsigned MAX_BINS   = DEF_MAX_BINS;
  localparam int unsigned NUM_TABLES = 2 * KINDS;
  localparam int unsigned PRINT_CAP  = 40;

  typedef logic [BINCNT_W-1:0] tally_t;

  typedef struct {
    logic [BINCNT_W-1:0] bin_count;
    logic [EXT_W-1:0]    extent_single;
    logic [EXT_W-1:0]    extent_pair;
    logic                orphan_mate;
  } bin_report_t;

  tally_t           per_read [KINDS][MAX_BINS];
  tally_t           per_pair [KINDS][MAX_BINS];
  logic [CNT_W-1:0] mate_counts [KINDS];
  logic             mate_held;
  int unsigned      top_read_bin;
  int unsigned      top_pair_bin;
  logic [LEN_W-1:0] length_reg;
  bin_report_t      due_results [$];

  task automatic report(string field, longint unsigned got, longint unsigned want);
    if (mismatches < PRINT_CAP) begin
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    end
    mismatches++;
  endtask

  // append one predicted result behind the ones still owed
  function automatic void queue_result(bin_report_t r);
    due_results = {due_results, r};
  endfunction

  // clamp a value to the top bin in use, saturate the counter, track the extent
  function automatic void count_value(bit pair_table, int unsigned kind, int unsigned value);
    int unsigned span;
    int unsigned bin;
    span = (length_reg == 0) ? 1 : ((length_reg > MAX_BINS) ? MAX_BINS : length_reg);
    bin  = (value >= span) ? span - 1 : value;
    if (pair_table) begin
      if (per_pair[kind][bin] != '1) per_pair[kind][bin]++;
      if (bin > top_pair_bin) top_pair_bin = bin;
    end else begin
      if (per_read[kind][bin] != '1) per_read[kind][bin]++;
      if (bin > top_read_bin) top_read_bin = bin;
    end
  endfunction

  function automatic bin_report_t apply_op();
    bin_report_t      r;
    logic [CNT_W-1:0] c [KINDS];
    int unsigned      sel;
    int unsigned      idx;
    c[0] = in_ch.mismatch_count;
    c[1] = in_ch.insertion_count;
    c[2] = in_ch.deletion_count;
    c[3] = in_ch.variant_count;
    c[4] = in_ch.diff_length;
    sel  = in_ch.table_select;
    idx  = in_ch.bin_index;
    r.bin_count   = '0;
    r.orphan_mate = 1'b0;
    if (in_ch.op == OP_READ) begin
      if (sel < NUM_TABLES && idx < MAX_BINS) begin
        r.bin_count = (sel < KINDS) ? per_read[sel][idx] : per_pair[sel - KINDS][idx];
      end
    end else begin
      for (int k = 0; k < KINDS; k++) count_value(1'b0, k, c[k]);
      if (in_ch.pair_role == ROLE_FIRST) begin
        mate_counts = c;
        mate_held   = 1'b1;
      end else if (in_ch.pair_role == ROLE_SECOND) begin
        if (mate_held) begin
          for (int k = 0; k < KINDS; k++) count_value(1'b1, k, int'(mate_counts[k]) + int'(c[k]));
          mate_held = 1'b0;
        end else begin
          r.orphan_mate = 1'b1;
        end
      end
    end
    r.extent_single = EXT_W'(top_read_bin + 1);
    r.extent_pair   = EXT_W'(top_pair_bin + 1);
    return r;
  endfunction

  always @(posedge clk) begin
    bin_report_t want;
    if (!rst_n) begin
      foreach (per_read[k, b]) begin
        per_read[k][b] = '0;
        per_pair[k][b] = '0;
      end
      foreach (mate_counts[k]) mate_counts[k] = '0;
      mate_held    = 1'b0;
      top_read_bin = 0;
      top_pair_bin = 0;
      length_reg   = REF_LEN_RST;
      due_results.delete();
    end else begin
      // results can only belong to earlier transfers, so compare before predicting
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          report("unexpected result", out_ch.bin_count, 0);
        end else begin
          want = due_results.pop_front();
          if (out_ch.bin_count != want.bin_count)
            report("bin_count", out_ch.bin_count, want.bin_count);
          if (out_ch.extent_single != want.extent_single)
            report("extent_single", out_ch.extent_single, want.extent_single);
          if (out_ch.extent_pair != want.extent_pair)
            report("extent_pair", out_ch.extent_pair, want.extent_pair);
          if (out_ch.orphan_mate != want.orphan_mate)
            report("orphan_mate", out_ch.orphan_mate, want.orphan_mate);
        end
      end
      if (cfg_valid && cfg_ready) length_reg = cfg_data;
      if (in_ch.valid && in_ch.ready) queue_result(apply_op());
    end
    pending_results <= due_results.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import vch_pkg::*;

  // Cycles with no transfer on any channel before the run is declared hung. Covers the
  // bin clearing pass after reset and the long receiver hold-off.
  localparam int unsigned STALL_LIMIT      = 3000;
  localparam int unsigned RANDOM_PER_PHASE = 175;
  localparam int unsigned SETTLE           = 8;
  localparam int unsigned IDLE_PCT         = 22;
  localparam int unsigned HOLD_AT_RESULT   = 300;
  localparam int unsigned HOLD_CYCLES      = 120;
  // unused pair role code, behaves as a read without mate
  localparam logic [ROLE_W-1:0] ROLE_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]              op;
    logic [ROLE_W-1:0]            pair_role;
    logic [KINDS-1:0][CNT_W-1:0]  counts;   // mismatch, insertion, deletion, variant, diff length
    logic [SEL_W-1:0]             table_select;
    logic [IDX_W-1:0]             bin_index;
  } histo_op_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data  = '0;
  int unsigned      pending_results;
  int unsigned      mismatches;
  int unsigned      tx_idle_pct = IDLE_PCT;
  bit               mate_open   = 1'b0;   // mirror of the held first-of-pair read

  vch_in_if  in_ch ();
  vch_out_if out_ch ();

  always #5 clk = ~clk;

  variant_count_histograms i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  vch_histogram_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .pending_results (pending_results),
    .mismatches      (mismatches)
  );

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic histo_op_t record_op(logic [ROLE_W-1:0] role, logic [CNT_W-1:0] mis,
                                          logic [CNT_W-1:0] ins, logic [CNT_W-1:0] del,
                                          logic [CNT_W-1:0] vnt, logic [CNT_W-1:0] edl);
    histo_op_t r;
    r           = '0;
    r.op        = OP_RECORD;
    r.pair_role = role;
    r.counts    = {edl, vnt, del, ins, mis};
    return r;
  endfunction

  function automatic histo_op_t bin_read(int unsigned sel, int unsigned idx);
    histo_op_t r;
    r              = '0;
    r.op           = OP_READ;
    r.table_select = SEL_W'(sel);
    r.bin_index    = IDX_W'(idx);
    return r;
  endfunction

  // Mostly values inside the bins in use, some just past the top bin, some anywhere.
  function automatic logic [CNT_W-1:0] random_count(int unsigned span);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return CNT_W'($urandom_range(0, span + 2));
    if (pick < 70) return CNT_W'($urandom_range(0, 15));
    if (pick < 90) return CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
    return pick[0] ? '1 : '0;
  endfunction

  // Favor complete pairs: once a first read is held, its mate usually follows.
  function automatic histo_op_t random_op(int unsigned span);
    histo_op_t   r;
    int unsigned pick;
    r.op = ($urandom_range(0, 99) < 70) ? OP_RECORD : OP_READ;
    r.table_select = ($urandom_range(0, 99) < 85) ? SEL_W'($urandom_range(0, 2 * KINDS - 1))
                                                  : SEL_W'($urandom_range(2 * KINDS,
                                                                          (1 << SEL_W) - 1));
    r.bin_index = ($urandom_range(0, 99) < 60)
                  ? IDX_W'($urandom_range(0, (span + 1 > DEF_MAX_BINS - 1) ? DEF_MAX_BINS - 1
                                                                          : span + 1))
                  : IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    for (int k = 0; k < KINDS; k++) r.counts[k] = random_count(span);
    pick = $urandom_range(0, 99);
    if (mate_open && pick < 75) begin
      r.pair_role = ROLE_SECOND;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      r.pair_role = ROLE_SOLO;
      else if (pick < 75) r.pair_role = ROLE_FIRST;
      else if (pick < 90) r.pair_role = ROLE_SECOND;   // mostly orphans here
      else                r.pair_role = ROLE_SPARE;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one op, with random idle cycles in front, and hold it until the transfer.
  // Valid stays high afterwards so back-to-back ops see no bubble.
  task automatic push(histo_op_t r);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.op              <= r.op;
    in_ch.pair_role       <= r.pair_role;
    in_ch.mismatch_count  <= r.counts[0];
    in_ch.insertion_count <= r.counts[1];
    in_ch.deletion_count  <= r.counts[2];
    in_ch.variant_count   <= r.counts[3];
    in_ch.diff_length     <= r.counts[4];
    in_ch.table_select    <= r.table_select;
    in_ch.bin_index       <= r.bin_index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (r.op == OP_RECORD) begin
      if (r.pair_role == ROLE_FIRST)       mate_open = 1'b1;
      else if (r.pair_role == ROLE_SECOND) mate_open = 1'b0;
    end
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline settle so the
  // block is fully idle before the next register write.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(logic [LEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Directed opening: field extremes, every pair role, orphan mate, a replaced first
  // read, the largest pair sums, and a read of every table select code.
  task automatic run_directed();
    push(bin_read(0, 0));                                   // empty histogram reads zero
    push(record_op(ROLE_SOLO, 0, 0, 0, 0, 0));
    push(record_op(ROLE_SOLO, '1, '1, '1, '1, '1));         // all clamp to the top bin
    push(record_op(ROLE_SPARE, 1, 2, 3, 4, 5));
    push(record_op(ROLE_SECOND, 2, 2, 2, 2, 2));            // mate with nothing held
    push(record_op(ROLE_FIRST, 1, 1, 1, 1, 1));
    push(record_op(ROLE_FIRST, '1, '1, '1, '1, '1));        // replaces the held read
    push(record_op(ROLE_SECOND, 0, 1, 0, 1, 0));
    push(record_op(ROLE_FIRST, '1, '1, '1, '1, '1));
    push(record_op(ROLE_SECOND, '1, '1, '1, '1, '1));       // widest pair sums
    for (int t = 0; t < (1 << SEL_W); t++) begin
      push(bin_read(t, (t == (1 << SEL_W) - 1) ? DEF_MAX_BINS - 1 : t % 4));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, one long hold-off that backs the block up into
  // its input, and a stretch with ready held high.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned taken;
    int unsigned hold_left;
    bit          held_once;
    taken        = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (!held_once && taken == HOLD_AT_RESULT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (taken >= 500 && taken < 800) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles in which no channel moves a transfer.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout after %0d quiet cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: one phase per reference length, in the listed order with one length drawn
  // at random; the extents only grow across the run and never shrink between phases.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [LEN_W-1:0] lengths [8];
    int unsigned      span;
    lengths    = '{10'd4, 10'd1, 10'd0, 10'd16, 10'd100, 10'd1023, 10'd300, 10'd512};
    lengths[6] = LEN_W'($urandom_range(2, DEF_MAX_BINS - 1));

    in_ch.valid           = 1'b0;
    in_ch.op              = OP_RECORD;
    in_ch.pair_role       = ROLE_SOLO;
    in_ch.mismatch_count  = '0;
    in_ch.insertion_count = '0;
    in_ch.deletion_count  = '0;
    in_ch.variant_count   = '0;
    in_ch.diff_length     = '0;
    in_ch.table_select    = '0;
    in_ch.bin_index       = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the bin clearing pass is over
    do @(posedge clk); while (!in_ch.ready);

    foreach (lengths[p]) begin
      if (p != 0) settle();
      write_length(lengths[p]);
      span = (lengths[p] == 0) ? 1 : ((lengths[p] > DEF_MAX_BINS) ? DEF_MAX_BINS : lengths[p]);
      // one phase runs the sender flat out
      tx_idle_pct = (p == 3) ? 0 : IDLE_PCT;
      if (p == 0) run_directed();
      repeat (RANDOM_PER_PHASE) push(random_op(span));
    end
    settle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
